/* sv/drnl_pkg.sv */
package drnl_pkg;

   localparam int NameBufferSize = 256;
   localparam logic [7:0] NameCap = 8'(NameBufferSize - 1);
   localparam logic [7:0] IdField = 8'd32;
   localparam logic [8:0] IdStart = 9'd33;
   localparam logic [9:0] EntryHead = 10'd4;
   localparam logic [7:0] CharN = 8'h4e;
   localparam logic [7:0] CharM = 8'h4d;
   localparam logic [7:0] CharSemi = 8'h3b;
   localparam logic [7:0] DotChar = 8'h00;
   localparam logic [7:0] DotDotChar = 8'h01;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      SIG_NONE = 2'd0,
      SIG_N    = 2'd1,
      SIG_NM   = 2'd3
   } sig_match_type;

   typedef enum logic [2:0] {
      KIND_PLAIN  = 3'd0,
      KIND_DOT    = 3'd1,
      KIND_DOTDOT = 3'd2,
      KIND_ALT    = 3'd3,
      KIND_BAD    = 3'd4
   } name_kind_type;

   typedef struct packed {
      logic [7:0] rec_len;
      logic [7:0] id_len;
      logic [7:0] first_char;
      logic [7:0] trimmed_len;
      logic       alt_found;
      logic [7:0] alt_offset;
      logic [7:0] alt_length;
   } rec_summary_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* sv/drnl_front.sv */
module drnl_front
   import drnl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_data,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,   // record_byte
   input  logic [0:0]      req_tuser,   // record_start
   input  queue_status_type q_status,
   output logic            push,
   output rec_summary_type summary
);

   logic [7:0] max_len_ff, max_len_in;
   logic [7:0] byte_index_ff, byte_index_in;
   logic [7:0] rec_len_ff, rec_len_in;
   logic [7:0] id_len_ff, id_len_in;
   logic [7:0] trimmed_ff, trimmed_in;
   logic       semi_ff, semi_in;
   logic [7:0] first_char_ff, first_char_in;
   logic [8:0] next_pos_ff, next_pos_in;
   sig_match_type sig_ff, sig_in;
   logic [7:0] entry_len_ff, entry_len_in;
   logic       stop_ff, stop_in;
   logic       alt_found_ff, alt_found_in;
   logic [7:0] alt_off_ff, alt_off_in;
   logic [7:0] alt_len_ff, alt_len_in;

   logic [7:0] b;
   logic [7:0] idx;
   logic [8:0] idx9;
   logic [8:0] rel;
   logic [7:0] nm_chars;
   logic [7:0] data_off;
   logic [7:0] cap;
   logic       last;
   logic       take;

   assign b = req_tdata;
   assign idx = req_tuser[0] ? 8'd0 : byte_index_ff;
   assign idx9 = {1'b0, idx};
   assign req_tready = !q_status.full;
   assign take = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign cap = (max_len_ff > NameCap) ? NameCap : max_len_ff;
   assign max_len_in = (csr_valid && csr_ready) ? csr_data : max_len_ff;

   always_comb begin
      byte_index_in = byte_index_ff;
      rec_len_in = rec_len_ff;
      id_len_in = id_len_ff;
      trimmed_in = trimmed_ff;
      semi_in = semi_ff;
      first_char_in = first_char_ff;
      next_pos_in = next_pos_ff;
      sig_in = sig_ff;
      entry_len_in = entry_len_ff;
      stop_in = stop_ff;
      alt_found_in = alt_found_ff;
      alt_off_in = alt_off_ff;
      alt_len_in = alt_len_ff;
      rel = idx9 - next_pos_ff;
      nm_chars = b - 8'd4;
      data_off = next_pos_ff[7:0] + 8'd4;
      if (nm_chars != 8'd0) begin
         data_off = data_off + 8'd1;
         nm_chars = nm_chars - 8'd1;
      end
      if (nm_chars > cap) begin
         nm_chars = cap;
      end
      priority if (idx == 8'd0) begin
         rec_len_in = b;
         id_len_in = 8'd0;
         trimmed_in = 8'd0;
         semi_in = 1'b0;
         first_char_in = 8'd0;
         next_pos_in = 9'd0;
         sig_in = SIG_NONE;
         entry_len_in = 8'd0;
         stop_in = 1'b0;
         alt_found_in = 1'b0;
         alt_off_in = 8'd0;
         alt_len_in = 8'd0;
      end else if (idx == IdField) begin
         id_len_in = b;
         next_pos_in = IdStart + {1'b0, b} + {8'd0, !b[0]};
      end else if (idx > IdField) begin
         if (idx9 < IdStart + {1'b0, id_len_ff}) begin
            if (idx9 == IdStart) begin
               first_char_in = b;
            end
            if (!semi_ff) begin
               if (b == CharSemi) begin
                  semi_in = 1'b1;
               end else begin
                  trimmed_in = trimmed_ff + 8'd1;
               end
            end
         end
         if (!stop_ff && idx9 >= next_pos_ff) begin
            priority if (rel == 9'd0) begin
               if ({1'b0, next_pos_ff} + EntryHead > {2'b0, rec_len_ff}) begin
                  stop_in = 1'b1;
               end else begin
                  sig_in = (b == CharN) ? SIG_N : SIG_NONE;
               end
            end else if (rel == 9'd1) begin
               sig_in = (sig_ff == SIG_N && b == CharM) ? SIG_NM : SIG_NONE;
            end else if (rel == 9'd2) begin
               entry_len_in = b;
               if (b < 8'd4 || {1'b0, next_pos_ff} + {2'b0, b} > {2'b0, rec_len_ff}) begin
                  stop_in = 1'b1;
               end else if (sig_ff == SIG_NM) begin
                  alt_found_in = 1'b1;
                  alt_off_in = data_off;
                  alt_len_in = nm_chars;
                  stop_in = 1'b1;
               end else begin
                  next_pos_in = next_pos_ff + {1'b0, b};
               end
            end else begin
            end
         end
      end else begin
      end
      last = (rec_len_in == 8'd0) || (idx9 + 9'd1 == {1'b0, rec_len_in});
      byte_index_in = last ? 8'd0 : idx + 8'd1;
   end

   assign push = take && last;
   assign summary.rec_len = rec_len_in;
   assign summary.id_len = id_len_in;
   assign summary.first_char = first_char_in;
   assign summary.trimmed_len = trimmed_in;
   assign summary.alt_found = alt_found_in;
   assign summary.alt_offset = alt_off_in;
   assign summary.alt_length = alt_len_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= 8'hff;
         byte_index_ff <= 8'd0;
         rec_len_ff <= 8'd0;
         id_len_ff <= 8'd0;
         trimmed_ff <= 8'd0;
         semi_ff <= 1'b0;
         first_char_ff <= 8'd0;
         next_pos_ff <= 9'd0;
         sig_ff <= SIG_NONE;
         entry_len_ff <= 8'd0;
         stop_ff <= 1'b0;
         alt_found_ff <= 1'b0;
         alt_off_ff <= 8'd0;
         alt_len_ff <= 8'd0;
      end else begin
         max_len_ff <= max_len_in;
         if (take) begin
            byte_index_ff <= byte_index_in;
            rec_len_ff <= rec_len_in;
            id_len_ff <= id_len_in;
            trimmed_ff <= trimmed_in;
            semi_ff <= semi_in;
            first_char_ff <= first_char_in;
            next_pos_ff <= next_pos_in;
            sig_ff <= sig_in;
            entry_len_ff <= entry_len_in;
            stop_ff <= stop_in;
            alt_found_ff <= alt_found_in;
            alt_off_ff <= alt_off_in;
            alt_len_ff <= alt_len_in;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_index_wraps: assert property (@(posedge clock) disable iff (reset)
      push |=> byte_index_ff == 8'd0)
      else $error("byte index not cleared after record end");
`endif

endmodule

/* sv/drnl_queue.sv */
module drnl_queue
   import drnl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rec_summary_type  push_data,
   input  logic             pop,
   output rec_summary_type  pop_data,
   output queue_status_type status
);

   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   rec_summary_type slot_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign status.full = (count_ff == CntW'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QueueDepth))
      else $error("queue count out of range");
`endif

endmodule

/* sv/drnl_back.sv */
module drnl_back
   import drnl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  rec_summary_type  summary,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,  // name_offset, name_length
   output logic [2:0]       rsp_tuser   // name_kind
);

   logic          valid_ff, valid_in;
   name_kind_type kind_ff, kind_in;
   logic [7:0]    offset_ff, offset_in;
   logic [7:0]    length_ff, length_in;
   logic          well_formed;

   assign pop = !q_status.empty && (!valid_ff || rsp_tready);
   assign well_formed = (summary.rec_len >= IdStart[7:0]) &&
                        (IdStart + {1'b0, summary.id_len} <= {1'b0, summary.rec_len});

   always_comb begin
      kind_in = KIND_BAD;
      offset_in = 8'd0;
      length_in = 8'd0;
      if (well_formed) begin
         priority if (summary.alt_found) begin
            kind_in = KIND_ALT;
            offset_in = summary.alt_offset;
            length_in = summary.alt_length;
         end else if (summary.id_len == 8'd1 && summary.first_char == DotChar) begin
            kind_in = KIND_DOT;
            offset_in = IdStart[7:0];
         end else if (summary.id_len == 8'd1 && summary.first_char == DotDotChar) begin
            kind_in = KIND_DOTDOT;
            offset_in = IdStart[7:0];
         end else begin
            kind_in = KIND_PLAIN;
            offset_in = IdStart[7:0];
            length_in = summary.trimmed_len;
         end
      end
      valid_in = pop ? 1'b1 : (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= kind_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {length_ff, offset_ff};
   assign rsp_tuser = kind_ff;

`ifndef NO_ASSERTIONS
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_BAD) |-> (offset_ff == 8'd0 && length_ff == 8'd0))
      else $error("malformed result with nonzero fields");
   a_dot_empty: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (kind_ff == KIND_DOT || kind_ff == KIND_DOTDOT)) |->
      (offset_ff == IdStart[7:0] && length_ff == 8'd0))
      else $error("dot result with bad fields");
`endif

endmodule

/* sv/dir_record_name_locator_unit.sv */
// channel   direction  handshake                 payload
// csr_      in         csr_valid / csr_ready     csr_data = max_name_length
// req_      in         req_tvalid / req_tready   tdata = record_byte, tuser = record_start
// rsp_      out        rsp_tvalid / rsp_tready   tdata = offset, length; tuser = kind
//
// one record byte per cycle; a result passes the summary queue, then the output register
// the parser stalls only when the two-entry summary queue is full
// results leave through a registered output stage that can hold while bytes keep flowing
// synchronous active-high reset; max_name_length returns to 255, parser to byte zero
module dir_record_name_locator_unit
   import drnl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // record_byte
   input  logic [0:0]  req_tuser,   // record_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // name_offset, name_length
   output logic [2:0]  rsp_tuser    // name_kind
);

   queue_status_type q_status;
   rec_summary_type  push_data;
   rec_summary_type  pop_data;
   logic             push;
   logic             pop;

   drnl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .summary    (push_data)
   );

   drnl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   drnl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .summary    (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
